FILE: design/jpip_msg_header_encoder_assert.svh
// Assertion macros shared by the header encoder modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef JPIP_MSG_HEADER_ENCODER_ASSERT_SVH
`define JPIP_MSG_HEADER_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JPIP_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JPIP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/jpip_pkg.sv
// ----------------------------------------------------------------------------
// jpip_pkg
// Shared widths, codes, command type and helper function of the JPIP
// message header encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jpip_pkg;

    // Field widths.
    localparam int CLASS_BITS  = 8;
    localparam int STREAM_BITS = 32;
    localparam int ROOM_BITS   = 16;
    localparam int VAL_BITS    = 64;
    localparam int GRP_BITS    = 7;
    localparam int CNT_BITS    = 4;
    localparam int TOTAL_BITS  = 6;

    // Encoding constants.
    localparam logic [7:0]  VBAS_CONT     = 8'h80;
    localparam logic [7:0]  EXT_BIT       = 8'h80;
    localparam logic [63:0] ID_SMALL_LIM  = 64'd16;

    // Presence codes.
    localparam logic [1:0] PRES_SAME   = 2'd1;
    localparam logic [1:0] PRES_CLASS  = 2'd2;
    localparam logic [1:0] PRES_STREAM = 2'd3;

    // One classified header, handed from the front to the back.
    typedef struct packed {
        logic                   ovf;
        logic [7:0]             first_byte;
        logic [1:0]             pres;
        logic                   has_id;
        logic [VAL_BITS-1:0]    id;
        logic [CLASS_BITS-1:0]  cls;
        logic [STREAM_BITS-1:0] strm;
        logic [VAL_BITS-1:0]    off;
        logic [VAL_BITS-1:0]    len;
        logic [CNT_BITS-1:0]    id_n;
        logic [CNT_BITS-1:0]    cls_n;
        logic [CNT_BITS-1:0]    strm_n;
        logic [CNT_BITS-1:0]    off_n;
        logic [CNT_BITS-1:0]    len_n;
    } cmd_t;

    // Number of seven-bit groups in the VBAS code of a value.
    function automatic logic [CNT_BITS-1:0] vbas_len(input logic [VAL_BITS-1:0] v);
        logic [CNT_BITS-1:0] n;
        n = CNT_BITS'(1);
        for (int g = 1; g < (VAL_BITS + GRP_BITS - 1) / GRP_BITS; g++)
        begin
            if ((v >> (GRP_BITS * g)) != '0)
            begin
                n = CNT_BITS'(g + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: design/jpip_if.sv
// ----------------------------------------------------------------------------
// jpip_if
// Valid/ready channels of the header encoder: header requests in, bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface jpip_req_if;
    logic                             valid;
    logic                             ready;
    logic [jpip_pkg::VAL_BITS-1:0]    bin_id;
    logic [7:0]                       bin_class;
    logic [31:0]                      stream_index;
    logic [jpip_pkg::VAL_BITS-1:0]    msg_offset;
    logic [jpip_pkg::VAL_BITS-1:0]    msg_length;
    logic                             final_flag;
    logic [15:0]                      room;

    modport source (output valid, bin_id, bin_class, stream_index, msg_offset,
                    msg_length, final_flag, room, input ready);
    modport sink   (input valid, bin_id, bin_class, stream_index, msg_offset,
                    msg_length, final_flag, room, output ready);
endinterface

interface jpip_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_header;
    logic       overflow;

    modport source (output valid, out_byte, end_of_header, overflow, input ready);
    modport sink   (input valid, out_byte, end_of_header, overflow, output ready);
endinterface

`default_nettype wire

FILE: design/jpip_front.sv
// ----------------------------------------------------------------------------
// jpip_front
// Accepts header requests, picks the presence, sizes every VBAS code, checks
// the total against the free room and queues one command per request.
// ----------------------------------------------------------------------------
`default_nettype none

module jpip_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    jpip_req_if.sink         req,
    input  wire logic        full,
    output logic             push,
    output jpip_pkg::cmd_t   push_data
);

    logic [jpip_pkg::CLASS_BITS-1:0]  prev_class_reg, prev_class_next;
    logic [jpip_pkg::STREAM_BITS-1:0] prev_stream_reg, prev_stream_next;
    logic                             ovf_seen_reg, ovf_seen_next;

    logic [jpip_pkg::CLASS_BITS-1:0]  cls;
    logic [jpip_pkg::STREAM_BITS-1:0] strm;
    logic [1:0]                       pres;
    logic                             has_id;
    logic [jpip_pkg::CNT_BITS-1:0]    id_n, cls_n, strm_n, off_n, len_n;
    logic [jpip_pkg::TOTAL_BITS-1:0]  total;
    logic                             ovf;

    // A request is taken whenever the queue has a free slot.
    assign req.ready = !full;
    assign push      = req.valid && !full;

    // Classification and sizing.
    always_comb
    begin
        cls    = req.bin_class[jpip_pkg::CLASS_BITS-1:0];
        strm   = req.stream_index[jpip_pkg::STREAM_BITS-1:0];
        pres   = jpip_pkg::PRES_SAME;
        if (prev_class_reg != cls)
        begin
            pres = jpip_pkg::PRES_CLASS;
        end
        if (prev_stream_reg != strm)
        begin
            pres = jpip_pkg::PRES_STREAM;
        end
        has_id = req.bin_id >= jpip_pkg::ID_SMALL_LIM;
        id_n   = jpip_pkg::vbas_len(req.bin_id);
        cls_n  = jpip_pkg::vbas_len(jpip_pkg::VAL_BITS'(cls));
        strm_n = jpip_pkg::vbas_len(jpip_pkg::VAL_BITS'(strm));
        off_n  = jpip_pkg::vbas_len(req.msg_offset);
        len_n  = jpip_pkg::vbas_len(req.msg_length);

        total = jpip_pkg::TOTAL_BITS'(1)
              + (has_id ? jpip_pkg::TOTAL_BITS'(id_n) : '0)
              + ((pres != jpip_pkg::PRES_SAME) ? jpip_pkg::TOTAL_BITS'(cls_n) : '0)
              + ((pres == jpip_pkg::PRES_STREAM) ? jpip_pkg::TOTAL_BITS'(strm_n) : '0)
              + jpip_pkg::TOTAL_BITS'(off_n)
              + jpip_pkg::TOTAL_BITS'(len_n);
        ovf = ovf_seen_reg
           || (jpip_pkg::ROOM_BITS'(total) > req.room[jpip_pkg::ROOM_BITS-1:0]);
    end

    // Command fields for the back end.
    always_comb
    begin
        push_data            = '0;
        push_data.ovf        = ovf;
        push_data.pres       = pres;
        push_data.has_id     = has_id;
        push_data.first_byte = {1'b0, pres, req.final_flag,
                                has_id ? 4'h0 : req.bin_id[3:0]};
        if (has_id)
        begin
            push_data.first_byte = push_data.first_byte | jpip_pkg::EXT_BIT;
        end
        push_data.id     = req.bin_id;
        push_data.cls    = cls;
        push_data.strm   = strm;
        push_data.off    = req.msg_offset;
        push_data.len    = req.msg_length;
        push_data.id_n   = id_n;
        push_data.cls_n  = cls_n;
        push_data.strm_n = strm_n;
        push_data.off_n  = off_n;
        push_data.len_n  = len_n;
    end

    // History update: an emitted header sets it, an overflow sticks.
    always_comb
    begin
        prev_class_next  = prev_class_reg;
        prev_stream_next = prev_stream_reg;
        ovf_seen_next    = ovf_seen_reg;
        if (push)
        begin
            if (ovf)
            begin
                ovf_seen_next = 1'b1;
            end
            else
            begin
                prev_class_next  = cls;
                prev_stream_next = strm;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_class_reg  <= '0;
            prev_stream_reg <= '0;
            ovf_seen_reg    <= 1'b0;
        end
        else
        begin
            prev_class_reg  <= prev_class_next;
            prev_stream_reg <= prev_stream_next;
            ovf_seen_reg    <= ovf_seen_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/jpip_queue.sv
// ----------------------------------------------------------------------------
// jpip_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jpip_msg_header_encoder_assert.svh"

module jpip_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire jpip_pkg::cmd_t  push_data,
    output logic                 full,
    input  wire logic            pop,
    output logic                 q_valid,
    output jpip_pkg::cmd_t       q_data
);

    jpip_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full    = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `JPIP_ASSERT_NOW(a_no_push_full, full, !push, "queue written while full")
    `JPIP_ASSERT_NOW(a_no_pop_empty, pop, q_valid, "queue read while empty")

endmodule

`default_nettype wire

FILE: design/jpip_back.sv
// ----------------------------------------------------------------------------
// jpip_back
// Takes queued commands and emits the header, one byte per cycle unless the
// output stalls, via a registered stage: first byte, then VBAS codes in order.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jpip_msg_header_encoder_assert.svh"

module jpip_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire jpip_pkg::cmd_t  q_data,
    output logic                 pop,
    jpip_rsp_if.source           rsp
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_ID,
        PH_CLS,
        PH_STRM,
        PH_OFF,
        PH_LEN
    } phase_t;

    jpip_pkg::cmd_t                cmd_reg, cmd_next;
    phase_t                        phase_reg, phase_next;
    logic                          busy_reg, busy_next;
    logic [jpip_pkg::CNT_BITS-1:0] grp_reg, grp_next;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_byte_reg, out_byte_next;
    logic                          out_eoh_reg, out_eoh_next;
    logic                          out_ovf_reg, out_ovf_next;

    logic                          out_adv;
    phase_t                        fld_next;
    logic [jpip_pkg::VAL_BITS-1:0] fld_val;
    logic [69:0]                   fld_ext;
    logic [6:0]                    grp_pos;
    logic [jpip_pkg::GRP_BITS-1:0] grp_bits;

    // Group count of the code emitted in a given phase.
    function automatic logic [jpip_pkg::CNT_BITS-1:0] field_len(input phase_t p,
                                                               input jpip_pkg::cmd_t c);
        logic [jpip_pkg::CNT_BITS-1:0] n;
        case (p)
            PH_ID:   n = c.id_n;
            PH_CLS:  n = c.cls_n;
            PH_STRM: n = c.strm_n;
            PH_OFF:  n = c.off_n;
            PH_LEN:  n = c.len_n;
            default: n = jpip_pkg::CNT_BITS'(1);
        endcase
        return n;
    endfunction

    assign rsp.valid         = out_valid_reg;
    assign rsp.out_byte      = out_byte_reg;
    assign rsp.end_of_header = out_eoh_reg;
    assign rsp.overflow      = out_ovf_reg;

    // The output stage can take a byte when empty or being drained.
    assign out_adv = !out_valid_reg || rsp.ready;
    assign pop     = !busy_reg && q_valid;

    // Phase that follows the current one for this header.
    always_comb
    begin
        case (phase_reg)
            PH_FIRST:
            begin
                if (cmd_reg.has_id)
                begin
                    fld_next = PH_ID;
                end
                else if (cmd_reg.pres != jpip_pkg::PRES_SAME)
                begin
                    fld_next = PH_CLS;
                end
                else
                begin
                    fld_next = PH_OFF;
                end
            end
            PH_ID:
            begin
                fld_next = (cmd_reg.pres != jpip_pkg::PRES_SAME) ? PH_CLS : PH_OFF;
            end
            PH_CLS:
            begin
                fld_next = (cmd_reg.pres == jpip_pkg::PRES_STREAM) ? PH_STRM : PH_OFF;
            end
            PH_STRM: fld_next = PH_OFF;
            PH_OFF:  fld_next = PH_LEN;
            default: fld_next = PH_LEN;
        endcase
    end

    // Seven-bit group selection, most significant group first.
    always_comb
    begin
        case (phase_reg)
            PH_ID:   fld_val = cmd_reg.id;
            PH_CLS:  fld_val = jpip_pkg::VAL_BITS'(cmd_reg.cls);
            PH_STRM: fld_val = jpip_pkg::VAL_BITS'(cmd_reg.strm);
            PH_OFF:  fld_val = cmd_reg.off;
            PH_LEN:  fld_val = cmd_reg.len;
            default: fld_val = '0;
        endcase
        fld_ext  = {6'd0, fld_val};
        grp_pos  = 7'(grp_reg - jpip_pkg::CNT_BITS'(1)) * 7'd7;
        grp_bits = fld_ext[grp_pos +: jpip_pkg::GRP_BITS];
    end

    // Sequencer and output stage.
    always_comb
    begin
        cmd_next       = cmd_reg;
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        grp_next       = grp_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_eoh_next   = out_eoh_reg;
        out_ovf_next   = out_ovf_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            cmd_next   = q_data;
            busy_next  = 1'b1;
            phase_next = PH_FIRST;
        end
        else if (busy_reg && out_adv)
        begin
            out_valid_next = 1'b1;
            if (phase_reg == PH_FIRST)
            begin
                out_byte_next = cmd_reg.ovf ? 8'h00 : cmd_reg.first_byte;
                out_eoh_next  = cmd_reg.ovf;
                out_ovf_next  = cmd_reg.ovf;
                if (cmd_reg.ovf)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    phase_next = fld_next;
                    grp_next   = field_len(fld_next, cmd_reg);
                end
            end
            else
            begin
                out_byte_next = {1'b0, grp_bits};
                if (grp_reg != jpip_pkg::CNT_BITS'(1))
                begin
                    out_byte_next = out_byte_next | jpip_pkg::VBAS_CONT;
                end
                out_eoh_next = (phase_reg == PH_LEN) && (grp_reg == jpip_pkg::CNT_BITS'(1));
                out_ovf_next = 1'b0;
                if (grp_reg == jpip_pkg::CNT_BITS'(1))
                begin
                    if (phase_reg == PH_LEN)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = fld_next;
                        grp_next   = field_len(fld_next, cmd_reg);
                    end
                end
                else
                begin
                    grp_next = grp_reg - jpip_pkg::CNT_BITS'(1);
                end
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= '0;
            phase_reg     <= PH_FIRST;
            busy_reg      <= 1'b0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_eoh_reg   <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            cmd_reg       <= cmd_next;
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_eoh_reg   <= out_eoh_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    `JPIP_ASSERT_NOW(a_ovf_alone, out_valid_reg && out_ovf_reg,
                     out_eoh_reg && (out_byte_reg == 8'h00),
                     "overflow result is not a lone zero byte")
    `JPIP_ASSERT_NOW(a_grp_live, busy_reg && (phase_reg != PH_FIRST), grp_reg != '0,
                     "group counter empty inside a code")
    `JPIP_ASSERT_NEXT(a_pop_start, pop, busy_reg && (phase_reg == PH_FIRST),
                      "command not started after pop")

endmodule

`default_nettype wire

FILE: design/jpip_msg_header_encoder.sv
// JPIP message header encoder.
// The req channel takes one request per message header (bin id, class,
// codestream index, offset, length, last-byte flag and free room); the rsp
// channel returns the header one byte per transfer, end_of_header marking the
// last byte. Both use valid/ready; a request moves when both are high.
// The back end loads the command, then passes each byte through the single
// byte-wide output register. Headers run from 3 to 38 bytes. An accepted
// request's command passes the queue entry and the command register before
// its first byte reaches the output register. A two-entry command queue lets
// the next requests be classified while a header is still being sent.
// When a header does not fit in room, or once any header has overflowed,
// a single result with out_byte 0, end_of_header 1 and overflow 1 is sent
// and the class and codestream history stay as they were.
// Reset clears the history, the sticky overflow flag, the queue and the
// output stage. A stalled receiver holds the current byte; the queue then
// fills and req.ready drops.
// ----------------------------------------------------------------------------
// jpip_msg_header_encoder
// Top level: front classifier, command queue and byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module jpip_msg_header_encoder (
    input  wire logic clk,
    input  wire logic rst_n,
    jpip_req_if.sink  req,
    jpip_rsp_if.source rsp
);

    logic           push;
    logic           full;
    logic           pop;
    logic           q_valid;
    jpip_pkg::cmd_t push_data;
    jpip_pkg::cmd_t q_data;

    // Request classification.
    jpip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    // Decoupling queue.
    jpip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    // Byte serializer.
    jpip_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

FILE: tb/tb_jpip_msg_header_encoder.sv
// ----------------------------------------------------------------------------
// tb_jpip_msg_header_encoder
// Self-checking bench for the JPIP message header encoder. Header requests
// go in with random gaps, and header bytes come out under random
// back-pressure. A scoreboard holds its own copy of the class and
// codestream history and the sticky overflow flag. It builds the expected
// byte stream for every accepted request and compares it byte by byte with
// the output channel.
// ----------------------------------------------------------------------------

module tb_jpip_msg_header_encoder;

    // Low seven bits of one VBAS group.
    localparam logic [63:0] GROUP_MASK = 64'h7F;

    // One header request as the bench sees it.
    typedef struct {
        logic [63:0]                      id;
        logic [jpip_pkg::CLASS_BITS-1:0]  cls;
        logic [jpip_pkg::STREAM_BITS-1:0] strm;
        logic [63:0]                      off;
        logic [63:0]                      len;
        logic                             final_flag;
        logic [jpip_pkg::ROOM_BITS-1:0]   room;
    } hdr_req_t;

    // One expected output byte.
    typedef struct {
        logic [7:0] data;
        logic       eoh;
        logic       ovf;
    } hdr_byte_t;

    // Header byte predictor and output checker.
    class header_scoreboard;
        logic [jpip_pkg::CLASS_BITS-1:0]  last_class;
        logic [jpip_pkg::STREAM_BITS-1:0] last_stream;
        bit                               refused;
        hdr_byte_t                        header_bytes[$];
        int unsigned                      error_count;
        int unsigned                      byte_count;

        function new();
            last_class  = '0;
            last_stream = '0;
            refused     = 1'b0;
            error_count = 0;
            byte_count  = 0;
        endfunction

        // Number of seven-bit groups needed for a value.
        function int unsigned group_count(logic [63:0] v);
            int unsigned n;
            logic [63:0] rest;
            n = 1;
            rest = v >> 7;
            while (rest != '0)
            begin
                n++;
                rest = rest >> 7;
            end
            return n;
        endfunction

        // Presence follows from comparing with the last emitted header.
        function logic [1:0] presence_of(hdr_req_t r);
            logic [1:0] pres;
            pres = jpip_pkg::PRES_SAME;
            if (r.cls != last_class)
            begin
                pres = jpip_pkg::PRES_CLASS;
            end
            if (r.strm != last_stream)
            begin
                pres = jpip_pkg::PRES_STREAM;
            end
            return pres;
        endfunction

        // Header size in bytes against the current history.
        function int unsigned header_total(hdr_req_t r);
            logic [1:0] pres;
            int unsigned total;
            pres = presence_of(r);
            total = 1 + group_count(r.off) + group_count(r.len);
            if (r.id >= jpip_pkg::ID_SMALL_LIM)
            begin
                total += group_count(r.id);
            end
            if (pres != jpip_pkg::PRES_SAME)
            begin
                total += group_count(64'(r.cls));
            end
            if (pres == jpip_pkg::PRES_STREAM)
            begin
                total += group_count(64'(r.strm));
            end
            return total;
        endfunction

        // Append one value as a VBAS code, most significant group first.
        function void push_vbas(logic [63:0] v);
            int n;
            hdr_byte_t b;
            n = int'(group_count(v));
            for (int k = n - 1; k >= 0; k--)
            begin
                b.data = 8'((v >> (7 * k)) & GROUP_MASK);
                if (k != 0)
                begin
                    b.data = b.data | jpip_pkg::VBAS_CONT;
                end
                b.eoh = 1'b0;
                b.ovf = 1'b0;
                header_bytes.push_back(b);
            end
        endfunction

        // Work out the bytes that an accepted request must produce.
        function void note_request(hdr_req_t r);
            logic [1:0] pres;
            hdr_byte_t b;
            pres = presence_of(r);
            // Refused request: one marker result and no history update.
            if (refused || header_total(r) > r.room)
            begin
                refused = 1'b1;
                b.data = 8'h00;
                b.eoh  = 1'b1;
                b.ovf  = 1'b1;
                header_bytes.push_back(b);
                return;
            end
            b.data = {1'b0, pres, r.final_flag, 4'h0};
            b.eoh  = 1'b0;
            b.ovf  = 1'b0;
            if (r.id < jpip_pkg::ID_SMALL_LIM)
            begin
                b.data[3:0] = r.id[3:0];
                header_bytes.push_back(b);
            end
            else
            begin
                b.data = b.data | jpip_pkg::EXT_BIT;
                header_bytes.push_back(b);
                push_vbas(r.id);
            end
            if (pres != jpip_pkg::PRES_SAME)
            begin
                push_vbas(64'(r.cls));
            end
            if (pres == jpip_pkg::PRES_STREAM)
            begin
                push_vbas(64'(r.strm));
            end
            push_vbas(r.off);
            push_vbas(r.len);
            header_bytes[header_bytes.size() - 1].eoh = 1'b1;
            last_class  = r.cls;
            last_stream = r.strm;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            error_count++;
        endtask

        // Compare one output byte with the oldest expectation.
        task check_result(logic [7:0] data, logic eoh, logic ovf);
            hdr_byte_t exp_b;
            if (header_bytes.size() == 0)
            begin
                report($sformatf("byte %0d: unexpected output %02h eoh=%b ovf=%b",
                                 byte_count, data, eoh, ovf));
            end
            else
            begin
                exp_b = header_bytes.pop_front();
                if (data !== exp_b.data)
                begin
                    report($sformatf("byte %0d: out_byte %02h, predicted %02h",
                                     byte_count, data, exp_b.data));
                end
                if (eoh !== exp_b.eoh)
                begin
                    report($sformatf("byte %0d: end_of_header %b, predicted %b",
                                     byte_count, eoh, exp_b.eoh));
                end
                if (ovf !== exp_b.ovf)
                begin
                    report($sformatf("byte %0d: overflow %b, predicted %b",
                                     byte_count, ovf, exp_b.ovf));
                end
            end
            byte_count++;
        endtask

        function int unsigned pending();
            return header_bytes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   send_calm;
    bit   recv_calm;

    header_scoreboard sb;

    jpip_req_if req_ch();
    jpip_rsp_if rsp_ch();

    jpip_msg_header_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Idle length: mostly short, now and then long.
    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned sender_gap();
        if (send_calm || $urandom_range(0, 1) == 0)
        begin
            return 0;
        end
        return idle_length();
    endfunction

    // Value with a random number of significant bits.
    function automatic logic [63:0] rand_wide();
        int unsigned nbits;
        logic [63:0] v;
        nbits = $urandom_range(0, 64);
        v = {$urandom, $urandom};
        if (nbits < 64)
        begin
            v = v & ((64'd1 << nbits) - 64'd1);
        end
        return v;
    endfunction

    function automatic hdr_req_t make_req(logic [63:0] id, logic [7:0] cls,
                                          logic [31:0] strm, logic [63:0] off,
                                          logic [63:0] len, logic fin);
        hdr_req_t r;
        r.id         = id;
        r.cls        = cls;
        r.strm       = strm;
        r.off        = off;
        r.len        = len;
        r.final_flag = fin;
        r.room       = '1;
        return r;
    endfunction

    // Random request that often repeats the last class or codestream.
    function automatic hdr_req_t random_request();
        hdr_req_t r;
        logic [63:0] s;
        r.id = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 15)) : rand_wide();
        r.cls = ($urandom_range(0, 1) == 0) ? sb.last_class : 8'($urandom_range(0, 255));
        s = rand_wide();
        r.strm = ($urandom_range(0, 4) < 3) ? sb.last_stream : s[31:0];
        r.off = rand_wide();
        r.len = rand_wide();
        r.final_flag = 1'($urandom_range(0, 1));
        r.room = '1;
        return r;
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input hdr_req_t r);
        int unsigned gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.bin_id       <= r.id;
        req_ch.bin_class    <= r.cls;
        req_ch.stream_index <= r.strm;
        req_ch.msg_offset   <= r.off;
        req_ch.msg_length   <= r.len;
        req_ch.final_flag   <= r.final_flag;
        req_ch.room         <= r.room;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(r);
    endtask

    // Random request sized to fit, often exactly or nearly.
    task automatic send_fitting();
        hdr_req_t r;
        int unsigned total;
        int unsigned pick;
        r = random_request();
        total = sb.header_total(r);
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            r.room = 16'(total);
        end
        else if (pick < 4)
        begin
            r.room = 16'(total + $urandom_range(1, 3));
        end
        else
        begin
            r.room = 16'($urandom_range(total, 65535));
        end
        send_request(r);
    endtask

    // Output side: check each accepted byte, stall at random.
    initial
    begin
        int unsigned stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_result(rsp_ch.out_byte, rsp_ch.end_of_header, rsp_ch.overflow);
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!recv_calm && $urandom_range(0, 3) == 0)
                begin
                    stall = idle_length();
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        hdr_req_t r;
        int unsigned total;
        sb = new();
        send_calm = 1'b0;
        recv_calm = 1'b0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.bin_id       <= '0;
        req_ch.bin_class    <= '0;
        req_ch.stream_index <= '0;
        req_ch.msg_offset   <= '0;
        req_ch.msg_length   <= '0;
        req_ch.final_flag   <= 1'b0;
        req_ch.room         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small and extended ids, each presence, group boundaries.
        send_request(make_req(64'd0, 8'd0, 32'd0, 64'd0, 64'd0, 1'b0));
        send_request(make_req(64'd15, 8'd0, 32'd0, 64'd1, 64'd1, 1'b1));
        send_request(make_req(64'd16, 8'd0, 32'd0, 64'd127, 64'd128, 1'b0));
        send_request(make_req('1, 8'd0, 32'd0, '1, '1, 1'b1));
        send_request(make_req(64'd3, 8'd5, 32'd0, 64'd0, 64'd0, 1'b0));
        // Longest possible header.
        send_request(make_req('1, 8'hFF, '1, '1, '1, 1'b1));
        send_request(make_req(64'd0, 8'hFF, '1, 64'd0, 64'd0, 1'b0));
        send_request(make_req(64'd17, 8'hFF, 32'd1, 64'd16383, 64'd16384, 1'b1));
        send_request(make_req(64'd127, 8'd0, 32'd1, 64'd128, 64'd127, 1'b0));
        send_request(make_req(64'd128, 8'd1, 32'h7F, 64'd2, 64'd3, 1'b0));
        send_request(make_req(64'h8000_0000_0000_0000, 8'h80, 32'h8000_0000,
                              64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1));
        send_request(make_req(64'h5555_5555_5555_5555, 8'h55, 32'h5555_5555,
                              64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0));
        send_request(make_req(64'hAAAA_AAAA_AAAA_AAAA, 8'hAA, 32'hAAAA_AAAA,
                              64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
        // Header that exactly fills the room.
        r = make_req(64'd20, 8'd200, 32'h8000_0000, 64'd300, 64'd5, 1'b0);
        r.room = 16'(sb.header_total(r));
        send_request(r);
        // Shortest header with the smallest room that holds it.
        r = make_req(64'd0, 8'd200, 32'h8000_0000, 64'd0, 64'd0, 1'b0);
        r.room = 16'(sb.header_total(r));
        send_request(r);
        r = make_req(64'd9, 8'd200, 32'd12345, 64'd1000, 64'd70000, 1'b1);
        r.room = 16'(sb.header_total(r) + 1);
        send_request(r);

        // Random headers, in segments with different idling on each side.
        for (int i = 0; i < 210; i++)
        begin
            case ((i / 30) % 4)
                0: begin send_calm = 1'b0; recv_calm = 1'b0; end
                1: begin send_calm = 1'b1; recv_calm = 1'b1; end
                2: begin send_calm = 1'b1; recv_calm = 1'b0; end
                default: begin send_calm = 1'b0; recv_calm = 1'b1; end
            endcase
            send_fitting();
        end

        // Overflow last, since it sticks until reset.
        send_calm = 1'b0;
        recv_calm = 1'b0;
        r = random_request();
        total = sb.header_total(r);
        r.room = 16'(total - 1);
        send_request(r);
        r = random_request();
        r.room = '0;
        send_request(r);
        for (int i = 0; i < 4; i++)
        begin
            send_request(random_request());
        end
        req_ch.valid <= 1'b0;

        // Drain, then watch a little longer for stray bytes.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (sb.error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/jpip_pkg.sv
design/jpip_if.sv
design/jpip_front.sv
design/jpip_queue.sv
design/jpip_back.sv
design/jpip_msg_header_encoder.sv
tb/tb_jpip_msg_header_encoder.sv
